/* rtl/cfrg_pkg.sv */
package cfrg_pkg;

	// Fixed point: signed, FRAC_BITS fraction bits
	localparam int FRAC_BITS = 16;
	localparam int CH_W      = 8;
	localparam int COLOR_W   = 3 * CH_W;
	localparam int NUM_CH    = 3;
	localparam int ITER_W    = 10;
	localparam int MODE_W    = 2;
	localparam int PHASE_W   = ITER_W + 1;

	// Quotient of (|diff| << FRAC_BITS) / n, and the signed step built from it
	localparam int DVD_W     = CH_W + FRAC_BITS;
	localparam int STEP_W    = DVD_W + 1;
	localparam int DIV_CNT_W = $clog2(DVD_W);

	// Levels: a level can be stepped up to 2^PHASE_W times between reloads when
	// iterations change between ticks, so the integer part carries 21 bits.
	localparam int LVL_INT_W = 21;
	localparam int LVL_W     = LVL_INT_W + FRAC_BITS;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = COLOR_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INITIAL_COLOR = 2'd0,
		REG_ENDING_COLOR  = 2'd1,
		REG_ITERATIONS    = 2'd2,
		REG_REPEAT_MODE   = 2'd3
	} cfg_reg_t;

	// Repeat mode bits; loop wins when both are set
	localparam int MODE_LOOP_BIT    = 0;
	localparam int MODE_REVERSE_BIT = 1;

	localparam logic [COLOR_W-1:0] DEFAULT_COLOR      = 24'hFFFFFF;
	localparam logic [ITER_W-1:0]  DEFAULT_ITERATIONS = 10'd1;
	localparam logic [MODE_W-1:0]  DEFAULT_MODE       = 2'd0;
	localparam logic [PHASE_W-1:0] PHASE_START        = 11'd2;
	localparam logic [PHASE_W-1:0] PHASE_LOOP         = 11'd1;

	typedef logic [CH_W-1:0]         chan_t;
	typedef logic signed [LVL_W-1:0] level_t;
	typedef logic signed [STEP_W-1:0] step_t;

	// Controller to datapath
	typedef struct packed {
		logic div_start;
		logic emit;
		logic restart;
	} cfrg_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic div_done;
		logic out_free;
	} cfrg_status_t;

	// Channel 0 red, 1 green, 2 blue
	function automatic chan_t chan(input logic [COLOR_W-1:0] color, input int c);
		chan_t r;
		r = color[(NUM_CH - 1 - c) * CH_W +: CH_W];
		return r;
	endfunction

	function automatic level_t to_fix(input chan_t v);
		level_t r;
		r = {{(LVL_W - CH_W - FRAC_BITS){1'b0}}, v, {FRAC_BITS{1'b0}}};
		return r;
	endfunction

	function automatic level_t step_ext(input step_t s);
		level_t r;
		r = {{(LVL_W - STEP_W){s[STEP_W-1]}}, s};
		return r;
	endfunction

	// Truncate to integer and clamp to 0..255
	function automatic chan_t to_byte(input level_t lv);
		chan_t r;
		if (lv[LVL_W-1]) begin
			r = '0;
		end else if (|lv[LVL_W-2:FRAC_BITS+CH_W]) begin
			r = '1;
		end else begin
			r = lv[FRAC_BITS +: CH_W];
		end
		return r;
	endfunction

endpackage

/* rtl/cfrg_in_if.sv */
interface cfrg_in_if;
	import cfrg_pkg::*;

	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);

endinterface

/* rtl/cfrg_out_if.sv */
interface cfrg_out_if;
	import cfrg_pkg::*;

	logic        valid;
	logic        ready;
	chan_t       red;
	chan_t       green;
	chan_t       blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);

endinterface

/* rtl/cfrg_div.sv */
// Three-lane restoring divider, one quotient bit per lane per cycle
module cfrg_div
	import cfrg_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [ITER_W-1:0]            divisor,
	input  logic [NUM_CH-1:0][CH_W-1:0]  mag,
	input  logic [NUM_CH-1:0]            neg,
	output step_t                        quot [NUM_CH],
	output logic                         done
);

	logic [NUM_CH-1:0][DVD_W-1:0]  dvd_q;
	logic [NUM_CH-1:0][ITER_W-1:0] rem_q;
	logic [NUM_CH-1:0]             neg_q;
	logic [ITER_W-1:0]             div_q;
	logic [DIV_CNT_W-1:0]          cnt_q;
	logic                          busy_q;
	logic                          done_q;

	logic [NUM_CH-1:0][DVD_W-1:0]  dvd_d;
	logic [NUM_CH-1:0][ITER_W-1:0] rem_d;

	// One restoring step per lane
	always_comb begin
		logic [ITER_W:0] trial;
		logic            ge;
		for (int c = 0; c < NUM_CH; c++) begin
			trial = {rem_q[c], dvd_q[c][DVD_W-1]};
			ge    = trial >= {1'b0, div_q};
			rem_d[c] = ge ? ITER_W'(trial - {1'b0, div_q}) : trial[ITER_W-1:0];
			dvd_d[c] = {dvd_q[c][DVD_W-2:0], ge};
		end
	end

	// Control of the iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(DVD_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Operands and partial results
	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			neg_q <= neg;
			for (int c = 0; c < NUM_CH; c++) begin
				dvd_q[c] <= {mag[c], {FRAC_BITS{1'b0}}};
				rem_q[c] <= '0;
			end
		end else if (busy_q) begin
			dvd_q <= dvd_d;
			rem_q <= rem_d;
		end
	end

	// Signed step from magnitude quotient
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			quot[c] = neg_q[c] ? -step_t'({1'b0, dvd_q[c]}) : step_t'({1'b0, dvd_q[c]});
		end
	end

	assign done = done_q;

endmodule

/* rtl/cfrg_dp.sv */
// Datapath: configuration registers, levels, steps, phase count, output register
module cfrg_dp
	import cfrg_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
	input  cfrg_cmd_t              cmd,
	output cfrg_status_t           st,
	input  logic                   out_ready,
	output logic                   out_valid,
	output chan_t                  out_red,
	output chan_t                  out_green,
	output chan_t                  out_blue
);

	logic [COLOR_W-1:0] initial_color_q;
	logic [COLOR_W-1:0] ending_color_q;
	logic [ITER_W-1:0]  iterations_q;
	logic [MODE_W-1:0]  repeat_mode_q;

	level_t             level_q [NUM_CH];
	step_t              step_q  [NUM_CH];
	logic [PHASE_W-1:0] phase_q;

	logic               out_valid_q;
	chan_t              out_byte_q [NUM_CH];

	level_t             level_d [NUM_CH];
	step_t              step_d  [NUM_CH];
	logic [PHASE_W-1:0] phase_d;
	chan_t              byte_d  [NUM_CH];

	logic                        small_ramp;
	logic [ITER_W-1:0]           n_frames;
	logic [PHASE_W-1:0]          top_phase;
	logic [NUM_CH-1:0][CH_W-1:0] diff_mag;
	logic [NUM_CH-1:0]           diff_neg;
	step_t                       quot [NUM_CH];
	logic                        div_done;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_color_q <= DEFAULT_COLOR;
			ending_color_q  <= DEFAULT_COLOR;
			iterations_q    <= DEFAULT_ITERATIONS;
			repeat_mode_q   <= DEFAULT_MODE;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_INITIAL_COLOR: initial_color_q <= cfg_wr_data;
				REG_ENDING_COLOR:  ending_color_q  <= cfg_wr_data;
				REG_ITERATIONS:    iterations_q    <= cfg_wr_data[ITER_W-1:0];
				REG_REPEAT_MODE:   repeat_mode_q   <= cfg_wr_data[MODE_W-1:0];
			endcase
		end
	end

	// Ramp length: zero and one iteration both give a constant colour
	assign small_ramp = iterations_q < ITER_W'(2);
	assign n_frames   = iterations_q - 1'b1;
	assign top_phase  = {n_frames, 1'b0} - PHASE_W'(2);

	// Per-channel difference, split into sign and magnitude for the divider
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			diff_neg[c] = chan(initial_color_q, c) < chan(ending_color_q, c);
			diff_mag[c] = diff_neg[c] ? chan(ending_color_q, c) - chan(initial_color_q, c)
			                          : chan(initial_color_q, c) - chan(ending_color_q, c);
		end
	end

	cfrg_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.divisor (n_frames),
		.mag     (diff_mag),
		.neg     (diff_neg),
		.quot    (quot),
		.done    (div_done)
	);

	// Next frame colour and state update
	always_comb begin
		logic phase_in_ramp;
		phase_in_ramp = phase_q <= {1'b0, n_frames};
		phase_d = phase_q;
		for (int c = 0; c < NUM_CH; c++) begin
			level_d[c] = level_q[c];
			step_d[c]  = step_q[c];
			byte_d[c]  = chan(initial_color_q, c);
		end
		if (cmd.restart) begin
			phase_d = PHASE_START;
			for (int c = 0; c < NUM_CH; c++) begin
				if (small_ramp) begin
					step_d[c]  = '0;
					level_d[c] = to_fix(chan(initial_color_q, c));
				end else begin
					step_d[c]  = quot[c];
					level_d[c] = to_fix(chan(initial_color_q, c)) - step_ext(quot[c]);
				end
			end
		end else if (!small_ramp) begin
			for (int c = 0; c < NUM_CH; c++) begin
				byte_d[c] = to_byte(level_q[c]);
			end
			if (phase_in_ramp) begin
				phase_d = phase_q + 1'b1;
				for (int c = 0; c < NUM_CH; c++) begin
					if (phase_q == {1'b0, n_frames}) begin
						level_d[c] = to_fix(chan(ending_color_q, c));
					end else begin
						level_d[c] = level_q[c] - step_ext(step_q[c]);
					end
				end
			end else if (repeat_mode_q[MODE_LOOP_BIT]) begin
				phase_d = PHASE_LOOP;
				for (int c = 0; c < NUM_CH; c++) begin
					level_d[c] = to_fix(chan(initial_color_q, c));
				end
			end else if (repeat_mode_q[MODE_REVERSE_BIT] && phase_q <= top_phase) begin
				phase_d = phase_q + 1'b1;
				for (int c = 0; c < NUM_CH; c++) begin
					level_d[c] = level_q[c] + step_ext(step_q[c]);
				end
			end else begin
				if (repeat_mode_q[MODE_REVERSE_BIT]) begin
					phase_d = PHASE_LOOP;
				end
				for (int c = 0; c < NUM_CH; c++) begin
					level_d[c] = to_fix(chan(initial_color_q, c));
				end
			end
		end
	end

	// Ramp state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PHASE_START;
			for (int c = 0; c < NUM_CH; c++) begin
				level_q[c] <= to_fix(chan(DEFAULT_COLOR, c));
				step_q[c]  <= '0;
			end
		end else if (cmd.emit) begin
			phase_q <= phase_d;
			level_q <= level_d;
			step_q  <= step_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_byte_q <= byte_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_red     = out_byte_q[0];
	assign out_green   = out_byte_q[1];
	assign out_blue    = out_byte_q[2];
	assign st.div_done = div_done;
	assign st.out_free = !out_valid_q || out_ready;

endmodule

/* rtl/cfrg_ctrl.sv */
// Controller: accepts a tick, runs the step division on restart, then emits
module cfrg_ctrl
	import cfrg_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic         in_restart,
	output logic         in_ready,
	input  cfrg_status_t st,
	output cfrg_cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIV  = 3'b010,
		S_EMIT = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   restart_q;
	logic   accept;

	assign in_ready = state_q == S_IDLE;
	assign accept   = in_valid && in_ready;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = in_restart ? S_DIV : S_EMIT;
				end
			end
			S_DIV: begin
				if (st.div_done) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (st.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			restart_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				restart_q <= in_restart;
			end
		end
	end

	// Commands
	assign cmd.div_start = accept && in_restart;
	assign cmd.emit      = (state_q == S_EMIT) && st.out_free;
	assign cmd.restart   = restart_q;

endmodule

/* rtl/color_fade_ramp_generator_top.sv */
// Colour fade ramp generator.
// in_ch carries one frame tick per transaction; restart high marks the first
// frame of a fade. out_ch returns one transaction per tick with that frame's
// red, green and blue. Registers are written over cfg_wr_en / cfg_index /
// cfg_wr_data (0 initial colour, 1 ending colour, 2 iterations, 3 repeat mode)
// by the user, who must do so only while no tick is in flight; the block
// itself does not enforce this. An ordinary tick goes through the emit state
// and then shows its colour on out_ch from the output register. A restart
// tick runs the step division first, in the restoring divider that yields one
// quotient bit per cycle over 24 bits (all three channels side by side). One
// tick is in flight at a time.
// Reset: both colours white, one iteration, hold mode; every tick then gives
// white until the registers are written and, for a ramp, a restart is sent.
// Stall: the result sits in the output register until taken; the next tick is
// accepted meanwhile and waits until that register frees up.
module color_fade_ramp_generator_top
	import cfrg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wr_data,
	cfrg_in_if.sink               in_ch,
	cfrg_out_if.source            out_ch
);

	cfrg_cmd_t    cmd;
	cfrg_status_t st;

	cfrg_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_ch.valid),
		.in_restart (in_ch.restart),
		.in_ready   (in_ch.ready),
		.st         (st),
		.cmd        (cmd)
	);

	cfrg_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.st          (st),
		.out_ready   (out_ch.ready),
		.out_valid   (out_ch.valid),
		.out_red     (out_ch.red),
		.out_green   (out_ch.green),
		.out_blue    (out_ch.blue)
	);

endmodule

/* rtl/cfrg_chk.sv */
// Port-level checks on the colour fade ramp generator
module cfrg_chk
	import cfrg_pkg::*;
(
	input logic  clk,
	input logic  arst_n,
	input logic  in_valid,
	input logic  in_ready,
	input logic  in_restart,
	input logic  out_valid,
	input logic  out_ready,
	input chan_t out_red,
	input chan_t out_green,
	input chan_t out_blue
);

	// A stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its colour
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_red) && $stable(out_green) && $stable(out_blue))
		else $error("result changed while stalled");

	// Only one tick in flight: input closes right after a transaction
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second tick taken while one is in flight");

	// A restart holds the input off during the division (sampled once, not throughout)
	a_restart_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_restart |-> ##2 !in_ready)
		else $error("input reopened during step division");

	// A new result never appears in the cycle right after a tick is taken
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_valid && in_ready))
		else $error("result appeared too early");

endmodule

bind color_fade_ramp_generator_top cfrg_chk u_cfrg_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.in_restart (in_ch.restart),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.out_red    (out_ch.red),
	.out_green  (out_ch.green),
	.out_blue   (out_ch.blue)
);
